/* rtl/core/ppb_pkg.sv */
// Package for the predecessor path backtrack block.
// Holds widths, table geometry, register map, payload and control types.
// No dependencies.
package ppb_pkg;

    localparam int NODE_W   = 12;
    localparam int SLOT_W   = 16;
    localparam int NODES    = 4096;
    localparam int ADDR_W   = $clog2(NODES);
    localparam int MAX_HOPS = 64;
    localparam int HOP_W    = $clog2(MAX_HOPS + 1);

    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic REG_START_NODE = 1'b0;
    localparam logic REG_CHECK      = 1'b1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_TRACE = 1'b1;

    typedef struct packed {
        logic              op;
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] pred_value;
        logic              pred_zero_real;
        logic [SLOT_W-1:0] path_slot;
    } t_in;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_tag;
        logic [NODE_W-1:0] node_id;
        logic              unreachable;
        logic              overrun;
        logic              last;
    } t_out;

    typedef struct packed {
        logic              zero_real;
        logic [NODE_W-1:0] pred;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WALK
    } t_state;

    typedef struct packed {
        logic load;
        logic capture;
        logic walking;
        logic first;
    } t_cmd;

    typedef struct packed {
        logic unreach;
        logic at_start;
        logic at_cap;
    } t_status;

endpackage

/* rtl/core/ppb_regs.sv */
// Configuration registers of the predecessor path backtrack block.
// APB-style write/read port; start node and unreachable-check enable.
// Depends on ppb_pkg.
module ppb_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ppb_pkg::PADDR_W-1:0]   paddr,
    input  logic [ppb_pkg::PDATA_W-1:0]   pwdata,
    output logic [ppb_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output logic [ppb_pkg::NODE_W-1:0]    o_start_node,
    output logic                          o_check
);
    import ppb_pkg::*;

    logic [NODE_W-1:0] r_start_node;
    logic              r_check;
    logic              wr_en;
    logic              reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_node <= '0;
            r_check      <= 1'b1;
        end else if (wr_en) begin
            case (reg_idx)
                REG_START_NODE: r_start_node <= pwdata[NODE_W-1:0];
                REG_CHECK:      r_check      <= pwdata[0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_START_NODE: prdata[NODE_W-1:0] = r_start_node;
            REG_CHECK:      prdata[0]          = r_check;
            default:        prdata             = '0;
        endcase
    end

    assign o_start_node = r_start_node;
    assign o_check      = r_check;

endmodule

/* rtl/core/ppb_ctrl.sv */
// Controller of the predecessor path backtrack block.
// Sequences load, target check and the hop-by-hop walk.
// Depends on ppb_pkg.
module ppb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_op,
    input  ppb_pkg::t_status  i_status,
    output ppb_pkg::t_cmd     o_cmd,
    output logic              o_busy
);
    import ppb_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   done;

    assign done = (r_state == ST_CHECK && i_status.unreach)
               || i_status.at_start || i_status.at_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start && i_op == OP_TRACE) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_state = done ? ST_IDLE : ST_WALK;
            end
            ST_WALK: begin
                if (done) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_busy        = 1'b0;
                o_cmd.load    = i_start && i_op == OP_LOAD;
                o_cmd.capture = i_start && i_op == OP_TRACE;
            end
            ST_CHECK: begin
                o_cmd.walking = 1'b1;
                o_cmd.first   = 1'b1;
            end
            ST_WALK: begin
                o_cmd.walking = 1'b1;
            end
            default: o_busy = 1'b0;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CHECK |-> $past(i_start) && $past(i_op) == OP_TRACE)
        else $error("check phase entered without a trace transaction");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_WALK |-> $past(r_state) != ST_IDLE)
        else $error("walk entered directly from idle");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.walking && done |=> r_state == ST_IDLE)
        else $error("controller did not return to idle after final hop");

endmodule

/* rtl/core/ppb_datapath.sv */
// Datapath of the predecessor path backtrack block.
// Predecessor table memory, walk registers, hop counter and result register.
// Depends on ppb_pkg.
module ppb_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ppb_pkg::t_cmd               i_cmd,
    input  ppb_pkg::t_in                i_item,
    input  logic [ppb_pkg::NODE_W-1:0]  i_start_node,
    input  logic                        i_check,
    output ppb_pkg::t_status            o_status,
    output logic                        o_valid,
    output ppb_pkg::t_out               o_result
);
    import ppb_pkg::*;

    t_entry mem [NODES];

    t_entry            r_rd;
    logic              r_rd_oob;
    logic [NODE_W-1:0] r_target;
    logic [SLOT_W-1:0] r_slot;
    logic [HOP_W-1:0]  r_hop;
    logic              r_valid;
    t_out              r_result;

    logic [NODE_W-1:0] rd_pred;
    logic              rd_flag;
    logic [NODE_W-1:0] cur;
    logic [NODE_W-1:0] rd_node;
    logic              rd_oob;
    logic              wr_oob;
    logic              unr;
    t_out              n_result;

    assign rd_pred = r_rd_oob ? '0 : r_rd.pred;
    assign rd_flag = r_rd_oob ? 1'b0 : r_rd.zero_real;
    assign cur     = i_cmd.first ? r_target : rd_pred;
    assign rd_node = i_cmd.walking ? cur : i_item.node;
    assign rd_oob  = {1'b0, rd_node} >= (NODE_W + 1)'(NODES);
    assign wr_oob  = {1'b0, i_item.node} >= (NODE_W + 1)'(NODES);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !wr_oob) begin
            mem[i_item.node[ADDR_W-1:0]] <= '{zero_real: i_item.pred_zero_real,
                                             pred: i_item.pred_value};
        end
        r_rd     <= mem[rd_node[ADDR_W-1:0]];
        r_rd_oob <= rd_oob;
    end

    assign o_status.unreach  = i_check && rd_pred == '0 && !rd_flag;
    assign o_status.at_start = i_cmd.walking && cur == i_start_node;
    assign o_status.at_cap   = i_cmd.walking && r_hop == HOP_W'(MAX_HOPS - 1);

    assign unr = i_cmd.first && o_status.unreach;

    always_comb begin
        n_result.slot_tag    = r_slot;
        n_result.node_id     = unr ? '0 : cur;
        n_result.unreachable = unr;
        n_result.overrun     = !unr && !o_status.at_start && o_status.at_cap;
        n_result.last        = unr || o_status.at_start || o_status.at_cap;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_target <= i_item.node;
            r_slot   <= i_item.path_slot;
        end
        r_result <= n_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hop   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.walking;
            if (i_cmd.capture) begin
                r_hop <= '0;
            end else if (i_cmd.walking) begin
                r_hop <= r_hop + HOP_W'(1);
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result.unreachable || o_result.overrun) |-> o_result.last)
        else $error("unreachable or overrun result not marked last");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.overrun |-> r_hop == HOP_W'(MAX_HOPS))
        else $error("overrun flagged before the hop cap");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hop <= HOP_W'(MAX_HOPS))
        else $error("hop counter beyond cap");

endmodule

/* rtl/core/predecessor_path_backtrack.sv */
// Top level of the predecessor path backtrack block.
// Instantiates ppb_regs, ppb_ctrl and ppb_datapath. Depends on ppb_pkg.
//
// Usage: a load transaction (op = 0) writes one predecessor table entry;
// busy stays low. A trace transaction (op = 1) keeps busy high while its
// results are formed, the first of which also checks the target; it gives
// at most MAX_HOPS = 64 results. The walk is bound by the single read port
// of the predecessor table, one hop read per cycle. Results are registered
// after they are formed, marked by o_valid, one per cycle in path order, and
// cannot be stalled. Reading table entries that were never loaded gives
// undefined paths. Configuration writes are taken at any time but belong in
// idle periods.
module predecessor_path_backtrack (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  ppb_pkg::t_in                 i_item,
    output logic                         o_valid,
    output ppb_pkg::t_out                o_result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ppb_pkg::PADDR_W-1:0]  paddr,
    input  logic [ppb_pkg::PDATA_W-1:0]  pwdata,
    output logic [ppb_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import ppb_pkg::*;

    logic [NODE_W-1:0] start_node;
    logic              check;
    t_cmd              cmd;
    t_status           status;

    ppb_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_start_node (start_node),
        .o_check      (check)
    );

    ppb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_op     (i_item.op),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    ppb_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_item       (i_item),
        .i_start_node (start_node),
        .i_check      (check),
        .o_status     (status),
        .o_valid      (o_valid),
        .o_result     (o_result)
    );

endmodule
